// File: hw/rtl/positional_list_engine_assert.svh
// Assertion macros used by the top level of the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Antecedent implies consequent in the next cycle.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg)
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/ple_pkg.sv
// Package with the types and codes of the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

	// Operation codes carried in the func field.
	typedef enum logic [2:0] {
		FUNC_INS_FRONT = 3'd0,
		FUNC_INS_BACK  = 3'd1,
		FUNC_INS_POS   = 3'd2,
		FUNC_DEL_FRONT = 3'd3,
		FUNC_DEL_BACK  = 3'd4,
		FUNC_DEL_POS   = 3'd5,
		FUNC_DUMP      = 3'd6
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic {
		S_IDLE = 1'b0,
		S_DUMP = 1'b1
	} state_t;

	// Input beat.
	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
		logic [4:0]         position;
	} item_t;

	// Result beat.
	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         entry_count;
		logic               has_value;
		logic signed [31:0] out_value;
		logic               last;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;
		logic dump_start;
		logic dump_step;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic dump_end;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/ple_ctrl.sv
// Controller state machine of the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
module ple_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [2:0]       func,
	input  wire ple_pkg::dp_stat_t stat,
	output logic                  busy,
	output ple_pkg::ctrl_cmd_t    cmd
);

	ple_pkg::state_t state_q;
	ple_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		busy = 1'b0;
		cmd = '0;
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				if (start) begin
					if (func == ple_pkg::FUNC_DUMP && !stat.empty) begin
						cmd.dump_start = 1'b1;
						state_d = ple_pkg::S_DUMP;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			ple_pkg::S_DUMP: begin
				busy = 1'b1;
				cmd.dump_step = 1'b1;
				if (stat.dump_end) begin
					state_d = ple_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ple_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/ple_dpath.sv
// Datapath of the positional list engine: entry cells, count and result register.
`timescale 1ns / 1ps
`default_nettype none
module ple_dpath #(
	parameter int CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ple_pkg::item_t     item,
	input  wire ple_pkg::ctrl_cmd_t cmd,
	output ple_pkg::dp_stat_t       stat,
	output ple_pkg::result_t        result,
	output logic                    strobe
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CW > 5) ? CW : 5;

	logic [31:0]      cells_q [CAPACITY];
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	logic [CW-1:0]    dcnt_q;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] pos_m1;
	logic [CMP_W-1:0] last_x;
	logic [CMP_W-1:0] idx;
	logic             full;
	logic             empty;
	logic             do_ins;
	logic             do_del;
	logic [1:0]       st;
	logic             strobe_q;
	ple_pkg::result_t res_q;

	assign cnt_x  = CMP_W'(count_q);
	assign pos_x  = CMP_W'(item.position);
	assign pos_m1 = pos_x - CMP_W'(1);
	assign last_x = cnt_x - CMP_W'(1);
	assign full   = (cnt_x == CMP_W'(CAPACITY));
	assign empty  = (count_q == '0);

	assign stat.empty    = empty;
	assign stat.dump_end = (CW'(dcnt_q + 1'b1) == count_q);

	// Decode the operation: checks, target index and status.
	always_comb begin
		do_ins = 1'b0;
		do_del = 1'b0;
		idx = '0;
		st = ple_pkg::STAT_OK;
		unique case (item.func)
			ple_pkg::FUNC_INS_FRONT: begin
				if (full) begin
					st = ple_pkg::STAT_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			ple_pkg::FUNC_INS_BACK: begin
				idx = cnt_x;
				if (full) begin
					st = ple_pkg::STAT_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			ple_pkg::FUNC_INS_POS: begin
				idx = pos_m1;
				if (pos_x == '0 || pos_m1 > cnt_x) begin
					st = ple_pkg::STAT_BADPOS;
				end else if (full) begin
					st = ple_pkg::STAT_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			ple_pkg::FUNC_DEL_FRONT: begin
				if (empty) begin
					st = ple_pkg::STAT_EMPTY;
				end else begin
					do_del = 1'b1;
				end
			end
			ple_pkg::FUNC_DEL_BACK: begin
				idx = last_x;
				if (empty) begin
					st = ple_pkg::STAT_EMPTY;
				end else begin
					do_del = 1'b1;
				end
			end
			ple_pkg::FUNC_DEL_POS: begin
				idx = pos_m1;
				if (empty) begin
					st = ple_pkg::STAT_EMPTY;
				end else if (pos_x == '0 || pos_m1 >= cnt_x) begin
					st = ple_pkg::STAT_BADPOS;
				end else begin
					do_del = 1'b1;
				end
			end
			ple_pkg::FUNC_DUMP: begin
				// Only a dump of an empty list reaches here.
				st = ple_pkg::STAT_OK;
			end
			default: begin
				st = ple_pkg::STAT_BADPOS;
			end
		endcase
	end

	// Count after the operation.
	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = CW'(count_q + 1'b1);
		end else if (do_del) begin
			count_d = CW'(count_q - 1'b1);
		end
	end

	// Entry cells: shift open, shift closed, or rotate the occupied part for a dump.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int PREV = (i > 0) ? i - 1 : 0;
		localparam int NEXT = (i < CAPACITY - 1) ? i + 1 : i;
		logic [CMP_W-1:0] i_x;
		assign i_x = CMP_W'(i);

		always_ff @(posedge clk) begin
			if (cmd.exec && do_ins) begin
				if (i_x == idx) begin
					cells_q[i] <= item.value;
				end else if (i_x > idx) begin
					cells_q[i] <= cells_q[PREV];
				end
			end else if (cmd.exec && do_del) begin
				if (i_x >= idx) begin
					cells_q[i] <= cells_q[NEXT];
				end
			end else if (cmd.dump_step) begin
				if (i_x == last_x) begin
					cells_q[i] <= cells_q[0];
				end else if (i_x < last_x) begin
					cells_q[i] <= cells_q[NEXT];
				end
			end
		end
	end

	// Count and dump counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.exec) begin
				count_q <= count_d;
			end
			if (cmd.dump_start) begin
				dcnt_q <= '0;
			end else if (cmd.dump_step) begin
				dcnt_q <= CW'(dcnt_q + 1'b1);
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.exec || cmd.dump_step;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q.status      <= st;
			res_q.entry_count <= 5'(count_d);
			res_q.has_value   <= 1'b0;
			res_q.out_value   <= '0;
			res_q.last        <= 1'b1;
		end else if (cmd.dump_step) begin
			res_q.status      <= ple_pkg::STAT_OK;
			res_q.entry_count <= 5'(count_q);
			res_q.has_value   <= 1'b1;
			res_q.out_value   <= cells_q[0];
			res_q.last        <= stat.dump_end;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule
`default_nettype wire

// File: hw/rtl/positional_list_engine.sv
// Top level of the positional list engine.
// Insert, delete and other single-result operations: result registered and shown in the
// cycle after the beat is taken, and a new beat can be taken every cycle while busy is low.
// Dump of N entries: busy while the cell chain rotates once per result; each result
// is registered from the front cell, and the last one is shown after busy falls.
// Reset clears the entry count and control state; the entry cells are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_assert.svh"
module positional_list_engine #(
	parameter int CAPACITY = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire ple_pkg::item_t item,
	output ple_pkg::result_t    result,
	output logic                strobe
);

	ple_pkg::ctrl_cmd_t cmd;
	ple_pkg::dp_stat_t  stat;
	logic               value_beat;
	logic               plain_beat;
	logic               zero_value;

	// Controller.
	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Datapath.
	ple_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result),
		.strobe (strobe)
	);

	// Result beat classes used by the checks below.
	assign value_beat = strobe && result.has_value;
	assign plain_beat = strobe && !result.has_value;
	assign zero_value = (result.out_value == 32'sd0);

	// A result without a value closes its operation and carries a zero value.
	`PLE_ASSERT_IMPL(a_novalue_last, plain_beat, result.last && zero_value, "bad valueless beat")
	// Dumped entries always report success.
	`PLE_ASSERT_IMPL(a_dump_ok, value_beat, result.status == ple_pkg::STAT_OK, "bad dump status")
	// The first dumped entry follows the cycle after busy rises.
	`PLE_ASSERT_NEXT(a_dump_first, $rose(busy), value_beat, "dump did not start streaming")
	// The final dumped entry is shown once the block is free again.
	`PLE_ASSERT_IMPL(a_dump_end_free, value_beat && result.last, !busy, "busy after final dump beat")

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the positional list engine: list edits, dumps and error status.
`timescale 1ns / 1ps
module tb_top;

	localparam int CAPACITY = 16;
	localparam int CYCLE_LIMIT = 200000;
	// Long enough to cover the tail of a full dump.
	localparam int TAIL_CYCLES = 2 * CAPACITY + 8;
	localparam int RANDOM_ITEMS = 256;
	// The one func code that the package leaves unassigned.
	localparam logic [2:0] FUNC_UNUSED = 3'd7;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             strobe;
	ple_pkg::item_t   item_bus = '0;
	ple_pkg::result_t result_bus;

	// Shadow copy of the list contents and the answers still to come.
	logic signed [31:0] shadow_vals [CAPACITY];
	int                 shadow_len;
	ple_pkg::result_t   due_answers [$];
	ple_pkg::result_t   want_beat;
	int unsigned        fail_count;
	int                 burst_left;

	positional_list_engine #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item_bus),
		.result(result_bus),
		.strobe(strobe)
	);

	// Free-running clock with a 10 ns period.
	always #5 clk = ~clk;

	// Put a value at a 0-based index, shifting the tail back by one.
	function automatic ple_pkg::status_t list_insert(input int idx,
			input logic signed [31:0] val);
		if (idx > shadow_len)
			return ple_pkg::STAT_BADPOS;
		if (shadow_len >= CAPACITY)
			return ple_pkg::STAT_FULL;
		for (int i = shadow_len; i > idx; i--)
			shadow_vals[i] = shadow_vals[i - 1];
		shadow_vals[idx] = val;
		shadow_len++;
		return ple_pkg::STAT_OK;
	endfunction

	// Take out the entry at a 0-based index, closing the gap.
	function automatic ple_pkg::status_t list_remove(input int idx);
		if (shadow_len == 0)
			return ple_pkg::STAT_EMPTY;
		if (idx >= shadow_len)
			return ple_pkg::STAT_BADPOS;
		for (int i = idx; i + 1 < shadow_len; i++)
			shadow_vals[i] = shadow_vals[i + 1];
		shadow_len--;
		return ple_pkg::STAT_OK;
	endfunction

	// Apply one accepted command to the shadow list and queue the answers it causes.
	task automatic apply_list_op(input ple_pkg::item_t it);
		ple_pkg::status_t st;
		ple_pkg::result_t beat;
		st = ple_pkg::STAT_OK;
		beat = '0;
		case (it.func)
			ple_pkg::FUNC_INS_FRONT: st = list_insert(0, it.value);
			ple_pkg::FUNC_INS_BACK:  st = list_insert(shadow_len, it.value);
			ple_pkg::FUNC_INS_POS:   st = (it.position == 0) ? ple_pkg::STAT_BADPOS :
				list_insert(int'(it.position) - 1, it.value);
			ple_pkg::FUNC_DEL_FRONT: st = list_remove(0);
			ple_pkg::FUNC_DEL_BACK:  st = (shadow_len == 0) ? ple_pkg::STAT_EMPTY :
				list_remove(shadow_len - 1);
			ple_pkg::FUNC_DEL_POS: begin
				if (shadow_len == 0)
					st = ple_pkg::STAT_EMPTY;
				else
					st = (it.position == 0) ? ple_pkg::STAT_BADPOS :
						list_remove(int'(it.position) - 1);
			end
			ple_pkg::FUNC_DUMP: st = ple_pkg::STAT_OK;
			default:   st = ple_pkg::STAT_BADPOS;
		endcase
		beat.status = st;
		beat.entry_count = 5'(shadow_len);
		// A dump of a non-empty list streams every entry, front first.
		if (it.func == ple_pkg::FUNC_DUMP && shadow_len > 0) begin
			for (int i = 0; i < shadow_len; i++) begin
				beat.has_value = 1'b1;
				beat.out_value = shadow_vals[i];
				beat.last = (i == shadow_len - 1);
				due_answers.push_back(beat);
			end
		end else begin
			beat.last = 1'b1;
			due_answers.push_back(beat);
		end
	endtask

	// Offer one command beat, wait until it is taken, then idle for the given gap.
	task automatic send_item(input ple_pkg::item_t it, input int gap);
		start <= 1'b1;
		item_bus <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_list_op(it);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender off until every queued answer has arrived.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (due_answers.size() != 0)
			@(posedge clk);
	endtask

	// Bursts of back-to-back beats separated by random gaps.
	function automatic int pick_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(0, 10);
		return ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
	endfunction

	// Values lean toward the extremes now and then.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh0;
			3: return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	function automatic ple_pkg::item_t make_item(input logic [2:0] func,
			input logic signed [31:0] val, input logic [4:0] pos);
		ple_pkg::item_t it;
		it.func = func;
		it.value = val;
		it.position = pos;
		return it;
	endfunction

	// Random command, mostly with a position that fits the current length.
	function automatic ple_pkg::item_t pick_item(input int insert_pct);
		ple_pkg::item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.value = pick_value();
		if (r < 3)
			it.func = FUNC_UNUSED;
		else if (r < 13)
			it.func = ple_pkg::FUNC_DUMP;
		else if (r < 13 + insert_pct)
			it.func = 3'($urandom_range(ple_pkg::FUNC_INS_FRONT, ple_pkg::FUNC_INS_POS));
		else
			it.func = 3'($urandom_range(ple_pkg::FUNC_DEL_FRONT, ple_pkg::FUNC_DEL_POS));
		if ($urandom_range(0, 4) == 0)
			it.position = 5'($urandom_range(0, 31));
		else if (it.func == ple_pkg::FUNC_DEL_POS)
			it.position = 5'((shadow_len == 0) ? 1 : $urandom_range(1, shadow_len));
		else
			it.position = 5'($urandom_range(1, shadow_len + 1));
		return it;
	endfunction

	// Compare one field of a result beat and log a mismatch.
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Every strobed result beat is matched against the oldest queued answer.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (due_answers.size() == 0) begin
				$error("result beat with no answer pending");
				fail_count++;
			end else begin
				want_beat = due_answers.pop_front();
				check_field("status", want_beat.status, result_bus.status);
				check_field("entry_count", want_beat.entry_count, result_bus.entry_count);
				check_field("has_value", want_beat.has_value, result_bus.has_value);
				check_field("out_value", want_beat.out_value, result_bus.out_value);
				check_field("last", want_beat.last, result_bus.last);
			end
		end
	end

	// Every error case on an empty list, plus the unassigned func code.
	task automatic test_empty_list();
		send_item(make_item(ple_pkg::FUNC_DUMP, 32'sd0, 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_DEL_FRONT, 32'sd0, 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_DEL_BACK, 32'sd0, 5'd0), 1);
		send_item(make_item(ple_pkg::FUNC_DEL_POS, 32'sd0, 5'd1), 0);
		send_item(make_item(ple_pkg::FUNC_DEL_POS, 32'sd0, 5'd0), 2);
		send_item(make_item(ple_pkg::FUNC_INS_POS, 32'sd5, 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_INS_POS, 32'sd5, 5'd2), 0);
		send_item(make_item(FUNC_UNUSED, 32'sh7fffffff, 5'd31), 1);
	endtask

	// Inserts and deletes at both ends and in the middle, with range edges.
	task automatic test_edit_ops();
		send_item(make_item(ple_pkg::FUNC_INS_FRONT, 32'sh7fffffff, 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_INS_BACK, 32'sh80000000, 5'd31), 0);
		send_item(make_item(ple_pkg::FUNC_INS_POS, -32'sd1, 5'd1), 1);
		send_item(make_item(ple_pkg::FUNC_INS_POS, 32'sd0, 5'd4), 0);
		send_item(make_item(ple_pkg::FUNC_INS_POS, 32'sh55555555, 5'd3), 0);
		send_item(make_item(ple_pkg::FUNC_INS_POS, 32'sh2aaaaaaa, 5'd7), 0);
		send_item(make_item(ple_pkg::FUNC_INS_POS, 32'sh2aaaaaaa, 5'd31), 3);
		send_item(make_item(ple_pkg::FUNC_DEL_POS, 32'sd0, 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_DEL_POS, 32'sd0, 5'd6), 0);
		send_item(make_item(ple_pkg::FUNC_DEL_POS, 32'sd0, 5'd3), 0);
		send_item(make_item(ple_pkg::FUNC_DUMP, 32'sd0, 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_DEL_FRONT, 32'sd0, 5'd0), 2);
		send_item(make_item(ple_pkg::FUNC_DEL_BACK, 32'sd0, 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_DEL_POS, 32'sd0, 5'd31), 0);
		send_item(make_item(ple_pkg::FUNC_DUMP, 32'sd0, 5'd0), 1);
	endtask

	// Fill to capacity, hit the full and range checks, dump, then empty it again.
	task automatic test_full_list();
		ple_pkg::item_t it;
		while (shadow_len < CAPACITY) begin
			it = make_item(3'($urandom_range(ple_pkg::FUNC_INS_FRONT, ple_pkg::FUNC_INS_POS)),
				pick_value(), 5'($urandom_range(1, shadow_len + 1)));
			send_item(it, pick_gap());
		end
		send_item(make_item(ple_pkg::FUNC_INS_FRONT, pick_value(), 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_INS_BACK, pick_value(), 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_INS_POS, pick_value(), 5'd1), 0);
		send_item(make_item(ple_pkg::FUNC_INS_POS, pick_value(), 5'd17), 0);
		send_item(make_item(ple_pkg::FUNC_INS_POS, pick_value(), 5'd18), 0);
		send_item(make_item(ple_pkg::FUNC_INS_POS, pick_value(), 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_DUMP, 32'sd0, 5'd0), 0);
		send_item(make_item(ple_pkg::FUNC_DUMP, 32'sd0, 5'd0), 0);
		wait_drained();
		while (shadow_len > 0) begin
			it = make_item(3'($urandom_range(ple_pkg::FUNC_DEL_FRONT, ple_pkg::FUNC_DEL_POS)),
				pick_value(), 5'($urandom_range(1, shadow_len)));
			send_item(it, pick_gap());
		end
		send_item(make_item(ple_pkg::FUNC_DEL_POS, 32'sd0, 5'd31), 0);
		send_item(make_item(ple_pkg::FUNC_DUMP, 32'sd0, 5'd0), 1);
	endtask

	// Random traffic that swings between growing and shrinking the list.
	task automatic test_random_traffic(input int count);
		bit grow;
		grow = 1'b1;
		for (int n = 0; n < count; n++) begin
			if (shadow_len >= CAPACITY)
				grow = 1'b0;
			else if (shadow_len == 0)
				grow = 1'b1;
			else if ($urandom_range(0, 29) == 0)
				grow = ~grow;
			send_item(pick_item(grow ? 65 : 25), pick_gap());
			if (n % 80 == 79)
				wait_drained();
		end
	endtask

	// Run limit in case the block stops answering.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_top failed");
		$finish;
	end

	// Reset, then the tests in turn, then the final verdict.
	initial begin
		fail_count = 0;
		shadow_len = 0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_edit_ops();
		test_full_list();
		test_random_traffic(RANDOM_ITEMS);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
